// ===== sv/wsm_pkg.sv =====
// Shared definitions for the wildcard string matcher.
// Item kinds, wildcard byte codes and the structs passed between modules.
// No dependencies.
package wsm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEFAULT = 64;

    // Item kinds carried in s_tuser
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Wildcard bytes in the pattern
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // One registered item handed to the matcher core
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] char_value;
    } step_t;

    // End-of-text verdict from the core
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

endpackage

// ===== sv/wsm_closure.sv =====
// Star closure of a set of reachable pattern positions.
// Log-depth prefix network: a reachable star carries reachability one position on.
// Depends on wsm_pkg for the default capacity only.
module wsm_closure #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic [PATTERN_MAX:0]   seed,      // reachable positions before closure
    input  logic [PATTERN_MAX-1:0] star_mask, // bit i: pattern byte i is a star
    output logic [PATTERN_MAX:0]   closed     // reachable positions after closure
);

    localparam int W      = PATTERN_MAX + 1;
    localparam int LEVELS = $clog2(W);

    // g: reachable so far; p: position j reachable from j-span through stars
    logic [W-1:0] g_lvl [LEVELS+1];
    logic [W-1:0] p_lvl [LEVELS];

    assign g_lvl[0] = seed;
    assign p_lvl[0] = {star_mask, 1'b0};

    genvar l, j;
    generate
        for (l = 0; l < LEVELS; l++) begin : g_level
            localparam int D = 1 << l;
            for (j = 0; j < W; j++) begin : g_bit
                if (j >= D) begin : g_span
                    assign g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j-D]);
                    if (l + 1 < LEVELS) begin : g_prop
                        assign p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j-D];
                    end
                end else begin : g_pass
                    assign g_lvl[l+1][j] = g_lvl[l][j];
                    if (l + 1 < LEVELS) begin : g_prop
                        assign p_lvl[l+1][j] = 1'b0;
                    end
                end
            end
        end
    endgenerate

    assign closed = g_lvl[LEVELS];

endmodule

// ===== sv/wsm_core.sv =====
// Matcher core: pattern store, length, overflow flag and reachable-position vector.
// One registered item is applied per cycle; the verdict for end of text is combinational.
// Depends on wsm_pkg and wsm_closure.
module wsm_core #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  wsm_pkg::step_t   step,    // item applied at this edge when valid
    output wsm_pkg::result_t result   // verdict for an end-of-text item
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Pattern bytes, valid below len_reg only
    logic [7:0]             store_reg [PATTERN_MAX];
    logic [LEN_W-1:0]       len_reg;
    logic                   ovf_reg;
    logic [PATTERN_MAX:0]   reach_reg;

    logic [PATTERN_MAX-1:0] in_len;
    logic [PATTERN_MAX-1:0] star_cur;
    logic [PATTERN_MAX-1:0] lit_hit;
    logic [PATTERN_MAX-1:0] len_onehot;
    logic [PATTERN_MAX-1:0] star_app;
    logic [PATTERN_MAX:0]   adv_seed;
    logic [PATTERN_MAX:0]   seed_sel;
    logic [PATTERN_MAX-1:0] star_sel;
    logic [PATTERN_MAX:0]   closed;
    logic [PATTERN_MAX:0]   start_set;
    logic                   room;

    assign room      = len_reg < LEN_W'(PATTERN_MAX);
    assign start_set = {{PATTERN_MAX{1'b0}}, 1'b1};

    // Per-position decode of the stored pattern against the current byte
    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++) begin : g_pos
            assign in_len[i]     = LEN_W'(i) < len_reg;
            assign len_onehot[i] = LEN_W'(i) == len_reg;
            assign star_cur[i]   = in_len[i] && (store_reg[i] == wsm_pkg::STAR_BYTE);
            assign lit_hit[i]    = in_len[i] && (store_reg[i] != wsm_pkg::STAR_BYTE) &&
                                   ((store_reg[i] == wsm_pkg::ANY_BYTE) ||
                                    (store_reg[i] == step.char_value));
        end

        // Advance by one text byte: stars hold, literal hits move on
        assign adv_seed[0] = reach_reg[0] & star_cur[0];
        for (i = 1; i < PATTERN_MAX; i++) begin : g_adv
            assign adv_seed[i] = (reach_reg[i] & star_cur[i]) | (reach_reg[i-1] & lit_hit[i-1]);
        end
        assign adv_seed[PATTERN_MAX] = reach_reg[PATTERN_MAX-1] & lit_hit[PATTERN_MAX-1];
    endgenerate

    // Star mask of the pattern after an append
    assign star_app = star_cur |
                      (((step.char_value == wsm_pkg::STAR_BYTE) && room) ?
                       len_onehot : {PATTERN_MAX{1'b0}});

    // Closure inputs by item kind
    always_comb
    begin
        unique case (step.kind)
            wsm_pkg::KIND_CLEAR:
            begin
                seed_sel = start_set;
                star_sel = '0;
            end
            wsm_pkg::KIND_APPEND:
            begin
                seed_sel = start_set;
                star_sel = star_app;
            end
            wsm_pkg::KIND_TEXT:
            begin
                seed_sel = adv_seed;
                star_sel = star_cur;
            end
            default:
            begin
                seed_sel = start_set;
                star_sel = star_cur;
            end
        endcase
    end

    wsm_closure #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_closure (
        .seed      (seed_sel),
        .star_mask (star_sel),
        .closed    (closed)
    );

    // Verdict for end of text
    assign result.matched          = !ovf_reg && reach_reg[len_reg];
    assign result.pattern_overflow = ovf_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            reach_reg <= {{PATTERN_MAX{1'b0}}, 1'b1};
        end
        else if (step.valid)
        begin
            reach_reg <= closed;
            unique case (step.kind)
                wsm_pkg::KIND_CLEAR:
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                wsm_pkg::KIND_APPEND:
                begin
                    if (room)
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pattern bytes, no reset
    always_ff @(posedge clk)
    begin
        if (step.valid && (step.kind == wsm_pkg::KIND_APPEND) && room)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= step.char_value;
        end
    end

    // A clear empties the pattern and drops the overflow flag
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && (step.kind == wsm_pkg::KIND_CLEAR) |=> (len_reg == '0) && !ovf_reg)
        else $error("clear did not empty the pattern");

    // Overflow only ever with a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_W'(PATTERN_MAX)))
        else $error("overflow flag with a store that is not full");

    // No position past the pattern end is reachable
    a_reach_range: assert property (@(posedge clk) disable iff (!rst_n)
        (reach_reg[PATTERN_MAX:1] & ~in_len) == '0)
        else $error("reachable position beyond pattern length");

endmodule

// ===== sv/wildcard_string_matcher_top.sv =====
// Top level of the wildcard string matcher: input register, core and result register.
// Depends on wsm_pkg and wsm_core.
//
//  channel | dir | tdata             | tuser              | transfer
//  s_*     | in  | [7:0] char_value  | [1:0] kind         | one item per transfer
//  m_*     | out | [0] matched       | [0] pattern_overflow | one result per end of text
//
// One item per cycle while no end-of-text item waits; the position update and star
// closure are combinational between the input register and the state registers.
// A result reaches m_* through the input register and then the result register.
// Reset empties the pattern; no clearing pass, items are taken right after reset.
// Only an end-of-text item waits, while the result register holds an untaken result.
module wildcard_string_matcher_top #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_value
    input  logic [1:0] s_tuser,   // [1:0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
    output logic [0:0] m_tuser    // [0] pattern_overflow
);

    logic             in_valid_reg;
    logic [1:0]       in_kind_reg;
    logic [7:0]       in_char_reg;
    logic             out_valid_reg;
    logic             out_match_reg;
    logic             out_ovf_reg;
    logic             go;
    logic             is_end;
    wsm_pkg::step_t   step;
    wsm_pkg::result_t result;

    // Held item goes to the core unless its result has nowhere to go
    assign is_end   = in_kind_reg == wsm_pkg::KIND_END;
    assign go       = in_valid_reg && !(is_end && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || go;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    assign step.valid      = go;
    assign step.kind       = in_kind_reg;
    assign step.char_value = in_char_reg;

    wsm_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && is_end)
        begin
            out_match_reg <= result.matched;
            out_ovf_reg   <= result.pattern_overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_match_reg};
    assign m_tuser  = out_ovf_reg;

    // An end of text taken by the core always leaves a result behind
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        go && is_end |=> out_valid_reg)
        else $error("end of text produced no result");

    // Overflow is never reported together with a match
    a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ovf_reg |-> !out_match_reg)
        else $error("match reported with pattern overflow");

    // A waiting result holds still until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while waiting");

endmodule
